// File: rtl/core/ptt_pkg.sv
`timescale 1ns / 1ps

package ptt_pkg;

  // Fixed field widths of the transaction ports.
  localparam int IN_HANDLE_W = 16;
  localparam int PERIOD_W    = 32;
  localparam int EVENT_W     = 3;
  localparam int ACTION_W    = 2;

  // Defaults for the top-level parameters.
  localparam int DEF_NUM_SLOTS   = 16;
  localparam int DEF_HANDLE_BITS = 16;

  // Action codes of an input transaction.
  localparam logic [ACTION_W-1:0] ACT_TICK       = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REGISTER   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UNREGISTER = 2'd2;

  // Result event codes.
  localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_FIRED     = 3'd1;
  localparam logic [EVENT_W-1:0] EV_REGISTERED = 3'd2;
  localparam logic [EVENT_W-1:0] EV_FULL      = 3'd3;
  localparam logic [EVENT_W-1:0] EV_REMOVED   = 3'd4;
  localparam logic [EVENT_W-1:0] EV_NOT_FOUND = 3'd5;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;   // take the bus (new entry written here)
    logic shift;  // rotate the chain by one slot
    logic tail;   // this cell is the last valid slot
  } cell_ctrl_t;

endpackage

// File: rtl/core/periodic_timer_table_top.sv
`timescale 1ns / 1ps

// Ordered table of periodic timers held in a ring of slot cells. A register
// transaction stays idle and its single result appears in the next
// cycle. A tick or unregister transaction with F timers in the table rotates the
// ring once through the head cell, one slot per cycle; busy stays high through
// the sweep and the finish state, and the finish state registers the last
// result. With an empty table it behaves like a register transaction. Fired
// results come out in table order, at most one per cycle; each one is held
// back until the next slot fires or the sweep closes, so that the final one
// can carry out_last. Results are shown for one cycle under out_strobe and
// cannot be held off, so the receiver must take every strobe. Action code 3
// is accepted and gives no result.
module periodic_timer_table_top
  import ptt_pkg::*;
#(
  parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [ACTION_W-1:0]    in_action,
  input  logic [IN_HANDLE_W-1:0] in_handle,
  input  logic [PERIOD_W-1:0]    in_period_ticks,
  output logic                   out_strobe,
  output logic [EVENT_W-1:0]     out_event_res,
  output logic [IN_HANDLE_W-1:0] out_fired_handle,
  output logic                   out_last
);

  localparam int FW   = $clog2(NUM_SLOTS + 1);
  localparam int HB_IN = (HANDLE_BITS < IN_HANDLE_W) ? HANDLE_BITS : IN_HANDLE_W;

  state_t state_r, state_nxt;

  logic [FW-1:0]          fill_r, fill_nxt;
  logic [FW-1:0]          step_r, step_nxt;
  logic [FW-1:0]          len_r, len_nxt;
  logic [ACTION_W-1:0]    act_r, act_nxt;
  logic [HANDLE_BITS-1:0] key_r, key_nxt;
  logic                   found_r, found_nxt;
  logic                   pend_r, pend_nxt;
  logic [IN_HANDLE_W-1:0] pend_handle_r, pend_handle_nxt;

  logic                   strobe_r, strobe_nxt;
  logic [EVENT_W-1:0]     event_r, event_nxt;
  logic [IN_HANDLE_W-1:0] ohandle_r, ohandle_nxt;
  logic                   last_r, last_nxt;

  // Chain wiring; the entry past the end feeds the last cell with zeros.
  logic [HANDLE_BITS-1:0] c_handle [NUM_SLOTS+1];
  logic [PERIOD_W-1:0]    c_period [NUM_SLOTS+1];
  logic [PERIOD_W-1:0]    c_count  [NUM_SLOTS+1];
  cell_ctrl_t             c_ctrl   [NUM_SLOTS];

  logic [HANDLE_BITS-1:0] bus_handle;
  logic [PERIOD_W-1:0]    bus_period;
  logic [PERIOD_W-1:0]    bus_count;

  logic [HANDLE_BITS-1:0] in_key;
  logic [PERIOD_W-1:0]    head_inc;
  logic                   head_fire;
  logic                   head_match;
  logic                   sweep_end;
  logic                   do_load;
  logic                   do_shift;
  logic                   do_drop;

  assign c_handle[NUM_SLOTS] = '0;
  assign c_period[NUM_SLOTS] = '0;
  assign c_count[NUM_SLOTS]  = '0;

  assign in_key = HANDLE_BITS'(in_handle[HB_IN-1:0]);

  // Head cell evaluation: the slot at cell 0 is the one being visited.
  assign head_inc   = c_count[0] + PERIOD_W'(1);
  assign head_fire  = (head_inc >= c_period[0]);
  assign head_match = (c_handle[0] == key_r) && !found_r;
  assign sweep_end  = (FW'(step_r + FW'(1)) == len_r);

  // Bus into the tail (sweep) or the free slot (register).
  always_comb begin
    if (state_r == ST_IDLE) begin
      bus_handle = in_key;
      bus_period = in_period_ticks;
      bus_count  = '0;
    end else begin
      bus_handle = c_handle[0];
      bus_period = c_period[0];
      if (act_r == ACT_TICK) begin
        bus_count = head_fire ? '0 : head_inc;
      end else begin
        bus_count = c_count[0];
      end
    end
  end

  assign do_load  = (state_r == ST_IDLE) && start && (in_action == ACT_REGISTER) &&
                    (fill_r != FW'(NUM_SLOTS));
  assign do_shift = (state_r == ST_SWEEP);
  assign do_drop  = do_shift && (act_r == ACT_UNREGISTER) && head_match;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
      // A dropped entry leaves the ring: the tail then takes nothing.
      assign c_ctrl[gi].load  = do_load && (fill_r == FW'(gi));
      assign c_ctrl[gi].shift = do_shift;
      assign c_ctrl[gi].tail  = (fill_r == FW'(gi + 1)) && !do_drop;

      ptt_cell #(
        .HANDLE_BITS(HANDLE_BITS)
      ) u_cell (
        .clk        (clk),
        .ctrl       (c_ctrl[gi]),
        .nbr_handle (c_handle[gi+1]),
        .nbr_period (c_period[gi+1]),
        .nbr_count  (c_count[gi+1]),
        .bus_handle (bus_handle),
        .bus_period (bus_period),
        .bus_count  (bus_count),
        .handle_q   (c_handle[gi]),
        .period_q   (c_period[gi]),
        .count_q    (c_count[gi])
      );
    end
  endgenerate

  // Sequencer state and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      strobe_r <= 1'b0;
      pend_r   <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      strobe_r <= strobe_nxt;
      pend_r   <= pend_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r        <= step_nxt;
    len_r         <= len_nxt;
    act_r         <= act_nxt;
    key_r         <= key_nxt;
    pend_handle_r <= pend_handle_nxt;
    event_r       <= event_nxt;
    ohandle_r     <= ohandle_nxt;
    last_r        <= last_nxt;
  end

  // Next state and result generation.
  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    step_nxt        = step_r;
    len_nxt         = len_r;
    act_nxt         = act_r;
    key_nxt         = key_r;
    found_nxt       = found_r;
    pend_nxt        = pend_r;
    pend_handle_nxt = pend_handle_r;
    strobe_nxt      = 1'b0;
    event_nxt       = EV_NONE;
    ohandle_nxt     = '0;
    last_nxt        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          key_nxt   = in_key;
          step_nxt  = '0;
          len_nxt   = fill_r;
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
          case (in_action)
            ACT_TICK: begin
              if (fill_r == '0) begin
                strobe_nxt = 1'b1;
                event_nxt  = EV_NONE;
                last_nxt   = 1'b1;
              end else begin
                state_nxt = ST_SWEEP;
              end
            end
            ACT_REGISTER: begin
              strobe_nxt = 1'b1;
              last_nxt   = 1'b1;
              if (fill_r == FW'(NUM_SLOTS)) begin
                event_nxt = EV_FULL;
              end else begin
                event_nxt   = EV_REGISTERED;
                ohandle_nxt = IN_HANDLE_W'(in_key[HB_IN-1:0]);
                fill_nxt    = FW'(fill_r + FW'(1));
              end
            end
            ACT_UNREGISTER: begin
              if (fill_r == '0) begin
                strobe_nxt = 1'b1;
                event_nxt  = EV_NOT_FOUND;
                last_nxt   = 1'b1;
              end else begin
                state_nxt = ST_SWEEP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SWEEP: begin
        step_nxt = FW'(step_r + FW'(1));
        if (act_r == ACT_TICK) begin
          // Hold one fired slot back so the final one can carry last.
          if (head_fire) begin
            if (pend_r) begin
              strobe_nxt  = 1'b1;
              event_nxt   = EV_FIRED;
              ohandle_nxt = pend_handle_r;
            end
            pend_nxt        = 1'b1;
            pend_handle_nxt = IN_HANDLE_W'(c_handle[0][HB_IN-1:0]);
          end
        end else if (head_match) begin
          found_nxt = 1'b1;
          fill_nxt  = FW'(fill_r - FW'(1));
        end
        if (sweep_end) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        if (act_r == ACT_TICK) begin
          if (pend_r) begin
            event_nxt   = EV_FIRED;
            ohandle_nxt = pend_handle_r;
          end else begin
            event_nxt = EV_NONE;
          end
        end else if (found_r) begin
          event_nxt   = EV_REMOVED;
          ohandle_nxt = IN_HANDLE_W'(key_r[HB_IN-1:0]);
        end else begin
          event_nxt = EV_NOT_FOUND;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = strobe_r;
  assign out_event_res    = event_r;
  assign out_fired_handle = ohandle_r;
  assign out_last         = last_r;

  // The table never holds more entries than it has slots.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(NUM_SLOTS))
    else $error("fill level above slot count");

  // Closing a sweep always delivers the final result of the transaction.
  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |=> (out_strobe && out_last))
    else $error("sweep finished without a final result");

  // Only fired results may be followed by more results of the same transaction.
  a_nonlast_fired: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> (out_event_res == EV_FIRED))
    else $error("non-final result that is not a fired event");

  // An unregister sweep removes at most one entry.
  a_single_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && act_r == ACT_UNREGISTER && found_r) |-> !do_drop)
    else $error("second entry dropped in one unregister sweep");

endmodule

// File: rtl/core/ptt_cell.sv
`timescale 1ns / 1ps

module ptt_cell
  import ptt_pkg::*;
#(
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic [HANDLE_BITS-1:0] nbr_handle,
  input  logic [PERIOD_W-1:0]    nbr_period,
  input  logic [PERIOD_W-1:0]    nbr_count,
  input  logic [HANDLE_BITS-1:0] bus_handle,
  input  logic [PERIOD_W-1:0]    bus_period,
  input  logic [PERIOD_W-1:0]    bus_count,
  output logic [HANDLE_BITS-1:0] handle_q,
  output logic [PERIOD_W-1:0]    period_q,
  output logic [PERIOD_W-1:0]    count_q
);

  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [PERIOD_W-1:0]    period_r, period_nxt;
  logic [PERIOD_W-1:0]    count_r, count_nxt;

  // Load and the shifting tail take the bus; other shifting cells take their neighbor.
  always_comb begin
    handle_nxt = handle_r;
    period_nxt = period_r;
    count_nxt  = count_r;
    if (ctrl.load || (ctrl.shift && ctrl.tail)) begin
      handle_nxt = bus_handle;
      period_nxt = bus_period;
      count_nxt  = bus_count;
    end else if (ctrl.shift) begin
      handle_nxt = nbr_handle;
      period_nxt = nbr_period;
      count_nxt  = nbr_count;
    end
  end

  always_ff @(posedge clk) begin
    handle_r <= handle_nxt;
    period_r <= period_nxt;
    count_r  <= count_nxt;
  end

  assign handle_q = handle_r;
  assign period_q = period_r;
  assign count_q  = count_r;

endmodule
